/* hw/rtl/fcbs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Floppy CHS service package
// Shared types, operation codes and geometry constants.
// ----------------------------------------------------------------------------
package fcbs_pkg;

    localparam int DRV_SLOTS = 2;
    localparam int CYL_W     = 10;
    localparam int SEC_W     = 6;
    localparam int TRK_W     = 18;
    localparam int DCYL_W    = 11;
    localparam int MEDIA_W   = 3;
    localparam int BLK_W     = 24;
    localparam int KB_W      = 16;
    localparam int EQ_W      = 16;

    typedef enum logic [3:0] {
        OP_MOUNT     = 4'd0,
        OP_RESET     = 4'd1,
        OP_READ      = 4'd2,
        OP_WRITE     = 4'd3,
        OP_FORMAT    = 4'd4,
        OP_PARAMS    = 4'd5,
        OP_DISKTYPE  = 4'd6,
        OP_SETTYPE   = 4'd7,
        OP_SETMEDIA  = 4'd8,
        OP_EQUIPMENT = 4'd9
    } op_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_DRIVE  = 2'd1,
        ST_BAD_SECTOR = 2'd2
    } status_t;

    localparam logic [KB_W-1:0]    KB_360         = 16'd360;
    localparam logic [KB_W-1:0]    KB_720         = 16'd720;
    localparam logic [MEDIA_W-1:0] MEDIA_360      = 3'd1;
    localparam logic [MEDIA_W-1:0] MEDIA_720      = 3'd3;
    localparam logic [MEDIA_W-1:0] MEDIA_1440     = 3'd4;
    localparam logic [MEDIA_W-1:0] DISKTYPE_FLOPPY = 3'd1;
    localparam logic [DCYL_W-1:0]  CYLS_40        = 11'd40;
    localparam logic [DCYL_W-1:0]  CYLS_80        = 11'd80;
    localparam logic [SEC_W-1:0]   SECS_9         = 6'd9;
    localparam logic [SEC_W-1:0]   SECS_18        = 6'd18;
    localparam logic [EQ_W-1:0]    EQUIP_TWO      = 16'h0041;
    localparam logic [EQ_W-1:0]    EQUIP_ONE      = 16'h0001;

    typedef struct packed {
        op_t               op;
        logic              drive_ok;
        logic              drive_sel;
        logic [CYL_W-1:0]  cyl;
        logic [SEC_W-1:0]  sec;
        logic [7:0]        head;
        logic [TRK_W-1:0]  trk;
        logic [KB_W-1:0]   kb;
    } req_t;

    typedef struct packed {
        logic               present;
        logic [DCYL_W-1:0]  cylinders;
        logic [SEC_W-1:0]   sectors;
        logic [MEDIA_W-1:0] media;
    } drive_info_t;

    typedef struct packed {
        logic               mount_en;
        logic               geom_en;
        logic               sel;
        logic [DCYL_W-1:0]  cylinders;
        logic [SEC_W-1:0]   sectors;
        logic [MEDIA_W-1:0] media;
    } drive_upd_t;

    // first member lands in the highest bits
    typedef struct packed {
        logic               drive_count;
        logic [7:0]         max_head;
        logic [7:0]         sector_field;
        logic [7:0]         max_cylinder_low;
        logic [MEDIA_W-1:0] media_type;
        logic [EQ_W-1:0]    equipment_word;
        logic [BLK_W-1:0]   block_address;
        status_t            status;
        logic               carry;
    } result_t;

endpackage

/* hw/rtl/floppy_chs_to_block_service.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Floppy CHS to block address service
// Two-drive floppy service: mount, range check and CHS to block translation.
// ----------------------------------------------------------------------------
// Takes one request per clock and returns one response per request. The
// response is offered once the request has passed the input register, then
// the result register. The drive table is updated as a request enters the
// result register, so a mount or set-media request is seen by the very next
// request. Only a stalled response port holds off new requests.
// ----------------------------------------------------------------------------
module floppy_chs_to_block_service
    import fcbs_pkg::*;
#(
    parameter int NUM_DRIVES = 2,
    parameter int HEADS      = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // operation[3:0], drive[11:4], cylinder_low[19:12], cyl_sector_byte[27:20],
    // head[35:28], image_kilobytes[51:36], zero[55:52]
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // carry[0], status[2:1], block_address[26:3], equipment_word[42:27],
    // media_type[45:43], max_cylinder_low[53:46], sector_field[61:54],
    // max_head[69:62], drive_count[70], zero[71]
    output logic [71:0] m_axis_tdata
);

    logic        req_valid;
    req_t        req;
    logic        advance;
    drive_info_t info;
    logic        present1;
    drive_upd_t  upd;
    result_t     result;

    fcbs_in_stage #(
        .NUM_DRIVES (NUM_DRIVES),
        .HEADS      (HEADS)
    ) u_in_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .advance       (advance),
        .req_valid     (req_valid),
        .req           (req)
    );

    fcbs_drive_table u_drive_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .sel      (req.drive_sel),
        .upd      (upd),
        .info     (info),
        .present1 (present1)
    );

    fcbs_exec #(
        .HEADS (HEADS)
    ) u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .advance   (advance),
        .info      (info),
        .present1  (present1),
        .upd       (upd),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .result    (result)
    );

    assign m_axis_tdata = {1'b0, result};

endmodule

/* hw/rtl/fcbs_in_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Floppy CHS service input stage
// Unpacks a request, decodes cylinder, sector and track, and registers it.
// ----------------------------------------------------------------------------
module fcbs_in_stage
    import fcbs_pkg::*;
#(
    parameter int NUM_DRIVES = 2,
    parameter int HEADS      = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,
    input  logic        advance,
    output logic        req_valid,
    output req_t        req
);

    logic             valid_reg;
    logic             valid_next;
    req_t             req_reg;
    req_t             req_next;
    logic             fire;
    logic [7:0]       drive_byte;
    logic [7:0]       csb;

    assign s_axis_tready = !valid_reg || advance;
    assign fire          = s_axis_tvalid && s_axis_tready;
    assign drive_byte    = s_axis_tdata[11:4];
    assign csb           = s_axis_tdata[27:20];

    always_comb
    begin
        req_next.op        = op_t'(s_axis_tdata[3:0]);
        req_next.drive_ok  = (drive_byte < 8'(NUM_DRIVES));
        req_next.drive_sel = drive_byte[0];
        req_next.cyl       = {csb[7:6], s_axis_tdata[19:12]};
        req_next.sec       = csb[5:0];
        req_next.head      = s_axis_tdata[35:28];
        req_next.kb        = s_axis_tdata[51:36];
        req_next.trk       = TRK_W'(HEADS) * TRK_W'(req_next.cyl) + TRK_W'(req_next.head);
    end

    always_comb
    begin
        if (fire)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            req_reg <= req_next;
        end
    end

    assign req_valid = valid_reg;
    assign req       = req_reg;

endmodule

/* hw/rtl/fcbs_drive_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Floppy CHS service drive table
// Per-drive presence and geometry registers with one update port.
// ----------------------------------------------------------------------------
module fcbs_drive_table
    import fcbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sel,
    input  drive_upd_t  upd,
    output drive_info_t info,
    output logic        present1
);

    logic               present_reg [DRV_SLOTS];
    logic [DCYL_W-1:0]  cyl_reg     [DRV_SLOTS];
    logic [SEC_W-1:0]   sec_reg     [DRV_SLOTS];
    logic [MEDIA_W-1:0] media_reg   [DRV_SLOTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DRV_SLOTS; i++)
            begin
                present_reg[i] <= 1'b0;
                cyl_reg[i]     <= '0;
                sec_reg[i]     <= '0;
                media_reg[i]   <= '0;
            end
        end
        else if (upd.mount_en)
        begin
            present_reg[upd.sel] <= 1'b1;
            cyl_reg[upd.sel]     <= upd.cylinders;
            sec_reg[upd.sel]     <= upd.sectors;
            media_reg[upd.sel]   <= upd.media;
        end
        else if (upd.geom_en)
        begin
            cyl_reg[upd.sel] <= upd.cylinders;
            sec_reg[upd.sel] <= upd.sectors;
        end
    end

    assign info.present   = present_reg[sel];
    assign info.cylinders = cyl_reg[sel];
    assign info.sectors   = sec_reg[sel];
    assign info.media     = media_reg[sel];
    assign present1       = present_reg[1];

endmodule

/* hw/rtl/fcbs_exec.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Floppy CHS service execute stage
// Runs one request against the drive table and registers its result.
// ----------------------------------------------------------------------------
module fcbs_exec
    import fcbs_pkg::*;
#(
    parameter int HEADS = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  req_t        req,
    output logic        advance,
    input  drive_info_t info,
    input  logic        present1,
    output drive_upd_t  upd,
    output logic        out_valid,
    input  logic        out_ready,
    output result_t     result
);

    logic              valid_reg;
    result_t           result_reg;
    result_t           res;
    drive_upd_t        upd_raw;
    logic              fire;
    logic [BLK_W-1:0]  track_start;
    logic [DCYL_W-1:0] max_cyl;
    logic              range_bad;

    assign advance     = !valid_reg || out_ready;
    assign fire        = req_valid && advance;
    assign track_start = BLK_W'(info.sectors) * BLK_W'(req.trk);
    assign max_cyl     = info.cylinders - DCYL_W'(1);
    assign range_bad   = (DCYL_W'(req.cyl) >= info.cylinders) || (req.head >= 8'(HEADS))
                      || (req.sec == '0) || (req.sec > info.sectors);

    always_comb
    begin
        res             = '0;
        res.status      = ST_OK;
        upd_raw         = '0;
        upd_raw.sel     = req.drive_sel;
        if (req.op == OP_EQUIPMENT)
        begin
            res.equipment_word = present1 ? EQUIP_TWO : EQUIP_ONE;
        end
        else if (req.op == OP_MOUNT)
        begin
            if (!req.drive_ok)
            begin
                res.carry  = 1'b1;
                res.status = ST_BAD_DRIVE;
            end
            else
            begin
                upd_raw.mount_en = 1'b1;
                if (req.kb == KB_360)
                begin
                    upd_raw.media     = MEDIA_360;
                    upd_raw.cylinders = CYLS_40;
                    upd_raw.sectors   = SECS_9;
                end
                else if (req.kb == KB_720)
                begin
                    upd_raw.media     = MEDIA_720;
                    upd_raw.cylinders = CYLS_80;
                    upd_raw.sectors   = SECS_9;
                end
                else
                begin
                    upd_raw.media     = MEDIA_1440;
                    upd_raw.cylinders = CYLS_80;
                    upd_raw.sectors   = SECS_18;
                end
                res.media_type = upd_raw.media;
            end
        end
        else if (!req.drive_ok || !info.present)
        begin
            res.carry  = 1'b1;
            res.status = ST_BAD_DRIVE;
        end
        else
        begin
            unique case (req.op)
                OP_RESET, OP_SETTYPE:
                begin
                end
                OP_READ, OP_WRITE:
                begin
                    if (range_bad)
                    begin
                        res.carry  = 1'b1;
                        res.status = ST_BAD_SECTOR;
                    end
                    else
                    begin
                        res.block_address = track_start + BLK_W'(req.sec) - BLK_W'(1);
                    end
                end
                OP_FORMAT:
                begin
                    res.block_address = track_start;
                end
                OP_PARAMS:
                begin
                    res.media_type       = info.media;
                    res.max_cylinder_low = max_cyl[7:0];
                    res.sector_field     = {max_cyl[9:8], info.sectors};
                    res.max_head         = 8'(HEADS - 1);
                    res.drive_count      = 1'b1;
                end
                OP_DISKTYPE:
                begin
                    res.media_type = DISKTYPE_FLOPPY;
                end
                OP_SETMEDIA:
                begin
                    upd_raw.geom_en   = 1'b1;
                    upd_raw.cylinders = DCYL_W'(req.cyl) + DCYL_W'(1);
                    upd_raw.sectors   = req.sec;
                end
                default:
                begin
                    res.carry = 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        upd          = upd_raw;
        upd.mount_en = upd_raw.mount_en && fire;
        upd.geom_en  = upd_raw.geom_en && fire;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign result    = result_reg;

`ifndef SYNTHESIS
    // a table write only happens while a request moves into the result register
    a_upd_with_fire: assert property (@(posedge clk) disable iff (!rst_n)
        (upd.mount_en || upd.geom_en) |-> (req_valid && advance))
        else $error("drive table written without a moving request");

    // a mount of drive one that was taken leaves drive one present for the next request
    a_mount_present: assert property (@(posedge clk) disable iff (!rst_n)
        upd.mount_en && (req.drive_sel == 1'b1) |=> present1)
        else $error("mounted drive one not present");

    // a failed status always raises carry
    a_status_carry: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && (result_reg.status != ST_OK) |-> result_reg.carry)
        else $error("error status without carry");

    // a failed request reports no block
    a_carry_block: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && result_reg.carry |-> (result_reg.block_address == '0))
        else $error("block address on failed request");
`endif

endmodule

/* verif/tb_floppy_chs_to_block_service.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Floppy CHS to block address service testbench
// Drives service requests into the request stream: first a table of directed
// corner cases, then random traffic that is mostly well-formed for the
// mounted geometry. A behavioral drive table predicts every response the
// directed table leaves open; each response is compared field by field, in
// order. Both stream sides idle at random. The response side also holds off
// once for a long stretch so that the block backs up into its request port.
// ----------------------------------------------------------------------------
module tb_floppy_chs_to_block_service;
    import fcbs_pkg::*;

    localparam int N_DRIVES     = 2;
    localparam int N_HEADS      = 2;
    localparam int RANDOM_COUNT = 1620;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AT      = 400;
    localparam int QUIET_FROM   = 900;
    localparam int QUIET_TO     = 1100;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 1000000;

    localparam logic [3:0] OP_UNKNOWN_LO = 4'd10;
    localparam logic [3:0] OP_UNKNOWN_HI = 4'd15;

    typedef struct {
        logic [3:0]  op;
        logic [7:0]  drive;
        logic [7:0]  cyl_lo;
        logic [7:0]  cyl_sec;
        logic [7:0]  head;
        logic [15:0] kb;
    } svc_req_t;

    typedef struct {
        svc_req_t req;
        bit       typed_in;
        result_t  want;
    } svc_row_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;

    logic               disk_loaded [N_DRIVES] = '{default: 1'b0};
    logic [DCYL_W-1:0]  disk_cyls   [N_DRIVES] = '{default: '0};
    logic [SEC_W-1:0]   disk_secs   [N_DRIVES] = '{default: '0};
    logic [MEDIA_W-1:0] disk_media  [N_DRIVES] = '{default: '0};

    result_t  expected_results[$];
    svc_row_t directed_rows[$];

    int  mismatches   = 0;
    int  resp_count   = 0;
    int  cycle_count  = 0;
    int  stall_left   = 0;
    int  hold_left    = 0;
    bit  hold_request = 1'b0;
    bit  hold_done    = 1'b0;
    bit  quiet        = 1'b0;

    floppy_chs_to_block_service #(
        .NUM_DRIVES (N_DRIVES),
        .HEADS      (N_HEADS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    function automatic result_t flat_result(bit carry, status_t st, logic [BLK_W-1:0] blk,
                                            logic [EQ_W-1:0] eq, logic [MEDIA_W-1:0] media);
        result_t res;
        res                = '0;
        res.carry          = carry;
        res.status         = st;
        res.block_address  = blk;
        res.equipment_word = eq;
        res.media_type     = media;
        return res;
    endfunction

    function automatic result_t service_predict(svc_req_t r);
        result_t     res;
        logic [9:0]  cyl;
        logic [5:0]  sec;
        logic [10:0] max_cyl;
        int unsigned trk;
        int          d;
        res = '0;
        cyl = {r.cyl_sec[7:6], r.cyl_lo};
        sec = r.cyl_sec[5:0];
        d   = r.drive[0];
        if (r.op == OP_EQUIPMENT)
        begin
            res.equipment_word = (N_DRIVES > 1 && disk_loaded[1]) ? EQUIP_TWO : EQUIP_ONE;
        end
        else if (r.op == OP_MOUNT)
        begin
            if (r.drive >= N_DRIVES)
            begin
                res.carry  = 1'b1;
                res.status = ST_BAD_DRIVE;
            end
            else
            begin
                if (r.kb == KB_360)
                begin
                    disk_media[d] = MEDIA_360;
                    disk_cyls[d]  = CYLS_40;
                    disk_secs[d]  = SECS_9;
                end
                else if (r.kb == KB_720)
                begin
                    disk_media[d] = MEDIA_720;
                    disk_cyls[d]  = CYLS_80;
                    disk_secs[d]  = SECS_9;
                end
                else
                begin
                    disk_media[d] = MEDIA_1440;
                    disk_cyls[d]  = CYLS_80;
                    disk_secs[d]  = SECS_18;
                end
                disk_loaded[d] = 1'b1;
                res.media_type = disk_media[d];
            end
        end
        else if (r.drive >= N_DRIVES || !disk_loaded[d])
        begin
            res.carry  = 1'b1;
            res.status = ST_BAD_DRIVE;
        end
        else
        begin
            trk = N_HEADS * cyl + r.head;
            case (r.op)
                OP_RESET, OP_SETTYPE:
                begin
                end
                OP_READ, OP_WRITE:
                begin
                    if (cyl >= disk_cyls[d] || r.head >= N_HEADS || sec == 0
                        || sec > disk_secs[d])
                    begin
                        res.carry  = 1'b1;
                        res.status = ST_BAD_SECTOR;
                    end
                    else
                    begin
                        res.block_address = BLK_W'(disk_secs[d] * trk + sec - 1);
                    end
                end
                OP_FORMAT:
                begin
                    res.block_address = BLK_W'(disk_secs[d] * trk);
                end
                OP_PARAMS:
                begin
                    max_cyl              = disk_cyls[d] - 11'd1;
                    res.media_type       = disk_media[d];
                    res.max_cylinder_low = max_cyl[7:0];
                    res.sector_field     = {max_cyl[9:8], disk_secs[d]};
                    res.max_head         = 8'(N_HEADS - 1);
                    res.drive_count      = 1'b1;
                end
                OP_DISKTYPE:
                begin
                    res.media_type = DISKTYPE_FLOPPY;
                end
                OP_SETMEDIA:
                begin
                    disk_cyls[d] = DCYL_W'(cyl + 1);
                    disk_secs[d] = sec;
                end
                default:
                begin
                    res.carry = 1'b1;
                end
            endcase
        end
        return res;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet)
            return 0;
        else if (roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else if (roll < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic svc_req_t random_request();
        svc_req_t    r;
        int          roll;
        int          d;
        logic [9:0]  cyl;
        r.op      = OP_READ;
        r.drive   = ($urandom_range(0, 99) < 88) ? 8'($urandom_range(0, 1))
                                                 : 8'($urandom_range(0, 255));
        r.cyl_lo  = 8'($urandom_range(0, 255));
        r.cyl_sec = 8'($urandom_range(0, 255));
        r.head    = 8'($urandom_range(0, 255));
        r.kb      = 16'($urandom_range(0, 65535));
        d         = r.drive[0];
        roll      = $urandom_range(0, 99);
        if (roll < 22)
            r.op = OP_READ;
        else if (roll < 44)
            r.op = OP_WRITE;
        else if (roll < 52)
            r.op = OP_FORMAT;
        else if (roll < 60)
            r.op = OP_PARAMS;
        else if (roll < 66)
            r.op = OP_MOUNT;
        else if (roll < 71)
            r.op = OP_SETMEDIA;
        else if (roll < 76)
            r.op = OP_EQUIPMENT;
        else if (roll < 80)
            r.op = OP_RESET;
        else if (roll < 84)
            r.op = OP_DISKTYPE;
        else if (roll < 88)
            r.op = OP_SETTYPE;
        else
            r.op = 4'($urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN_HI));

        if ((r.op == OP_READ || r.op == OP_WRITE) && $urandom_range(0, 99) < 75
            && disk_cyls[d] != 0 && disk_secs[d] != 0)
        begin
            cyl       = 10'($urandom_range(0, disk_cyls[d] - 1));
            r.cyl_lo  = cyl[7:0];
            r.cyl_sec = {cyl[9:8], 6'($urandom_range(1, disk_secs[d]))};
            r.head    = 8'($urandom_range(0, N_HEADS - 1));
        end
        else if (r.op == OP_FORMAT && $urandom_range(0, 1) == 0)
        begin
            r.head = 8'($urandom_range(0, N_HEADS - 1));
        end
        else if (r.op == OP_MOUNT)
        begin
            roll = $urandom_range(0, 2);
            if (roll == 0)
                r.kb = KB_360;
            else if (roll == 1)
                r.kb = KB_720;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("response %0d: %s", resp_count, msg);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input longint unsigned got,
                                 input longint unsigned want);
        if (got != want)
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    task automatic add_row(input logic [3:0] op, input logic [7:0] drive,
                           input logic [7:0] cyl_lo, input logic [7:0] cyl_sec,
                           input logic [7:0] head, input logic [15:0] kb,
                           input bit typed_in, input result_t want);
        svc_row_t row;
        row.req.op      = op;
        row.req.drive   = drive;
        row.req.cyl_lo  = cyl_lo;
        row.req.cyl_sec = cyl_sec;
        row.req.head    = head;
        row.req.kb      = kb;
        row.typed_in    = typed_in;
        row.want        = want;
        directed_rows.push_back(row);
    endtask

    task automatic send_request(input svc_req_t r, input bit typed_in, input result_t want);
        int      gap;
        result_t predicted;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, r.kb, r.head, r.cyl_sec, r.cyl_lo, r.drive, r.op};
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        predicted = service_predict(r);
        expected_results.push_back(typed_in ? want : predicted);
    endtask

    // response side: random stalls, one long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else if (hold_request && !hold_done)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            hold_done     <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else
        begin
            stall_left    <= pick_gap();
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected response 0x%0h", m_axis_tdata));
            end
            else
            begin
                result_t got;
                result_t want;
                got  = result_t'(m_axis_tdata[70:0]);
                want = expected_results.pop_front();
                compare_field("carry", got.carry, want.carry);
                compare_field("status", got.status, want.status);
                compare_field("block_address", got.block_address, want.block_address);
                compare_field("equipment_word", got.equipment_word, want.equipment_word);
                compare_field("media_type", got.media_type, want.media_type);
                compare_field("max_cylinder_low", got.max_cylinder_low,
                              want.max_cylinder_low);
                compare_field("sector_field", got.sector_field, want.sector_field);
                compare_field("max_head", got.max_head, want.max_head);
                compare_field("drive_count", got.drive_count, want.drive_count);
                compare_field("pad", m_axis_tdata[71], 0);
            end
            resp_count++;
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        result_t bad_drive;
        result_t bad_sector;
        result_t none;
        svc_req_t r;
        bad_drive  = flat_result(1'b1, ST_BAD_DRIVE, '0, '0, '0);
        bad_sector = flat_result(1'b1, ST_BAD_SECTOR, '0, '0, '0);
        none       = flat_result(1'b0, ST_OK, '0, '0, '0);

        add_row(OP_EQUIPMENT, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 1,
                flat_result(1'b0, ST_OK, '0, EQUIP_ONE, '0));
        add_row(OP_READ, 8'd0, 8'd0, 8'd1, 8'd0, 16'd0, 1, bad_drive);
        add_row(OP_PARAMS, 8'd1, 8'd0, 8'd0, 8'd0, 16'd0, 1, bad_drive);
        add_row(OP_MOUNT, 8'hff, 8'hff, 8'hff, 8'hff, 16'hffff, 1, bad_drive);
        add_row(OP_MOUNT, 8'd0, 8'd0, 8'd0, 8'd0, KB_360, 1,
                flat_result(1'b0, ST_OK, '0, '0, MEDIA_360));
        add_row(OP_MOUNT, 8'd1, 8'd0, 8'd0, 8'd0, KB_720, 1,
                flat_result(1'b0, ST_OK, '0, '0, MEDIA_720));
        add_row(OP_EQUIPMENT, 8'hff, 8'd0, 8'd0, 8'd0, 16'd0, 1,
                flat_result(1'b0, ST_OK, '0, EQUIP_TWO, '0));
        add_row(OP_READ, 8'd0, 8'd0, 8'd1, 8'd0, 16'd0, 1, none);
        add_row(OP_READ, 8'd0, 8'd39, 8'd9, 8'd1, 16'd0, 0, none);
        add_row(OP_WRITE, 8'd0, 8'd40, 8'd1, 8'd0, 16'd0, 1, bad_sector);
        add_row(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 1, bad_sector);
        add_row(OP_READ, 8'd0, 8'd0, 8'd1, 8'd2, 16'd0, 1, bad_sector);
        add_row(OP_WRITE, 8'd1, 8'd0, 8'd10, 8'd0, 16'd0, 1, bad_sector);
        add_row(OP_FORMAT, 8'd1, 8'hff, 8'hc0, 8'hff, 16'd0, 0, none);
        add_row(OP_PARAMS, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 0, none);
        add_row(OP_DISKTYPE, 8'd1, 8'd0, 8'd0, 8'd0, 16'd0, 1,
                flat_result(1'b0, ST_OK, '0, '0, DISKTYPE_FLOPPY));
        add_row(OP_SETTYPE, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 1, none);
        add_row(OP_RESET, 8'd1, 8'd0, 8'd0, 8'd0, 16'd0, 1, none);
        add_row(OP_UNKNOWN_HI, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 1,
                flat_result(1'b1, ST_OK, '0, '0, '0));
        add_row(OP_SETMEDIA, 8'd0, 8'hff, 8'hff, 8'd0, 16'd0, 1, none);
        add_row(OP_PARAMS, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 0, none);
        add_row(OP_READ, 8'd0, 8'hff, 8'hff, 8'd1, 16'd0, 0, none);
        add_row(OP_SETMEDIA, 8'd1, 8'd0, 8'd0, 8'd0, 16'd0, 1, none);
        add_row(OP_READ, 8'd1, 8'd0, 8'd1, 8'd0, 16'd0, 1, bad_sector);
        add_row(OP_MOUNT, 8'd0, 8'd0, 8'd0, 8'd0, 16'hffff, 1,
                flat_result(1'b0, ST_OK, '0, '0, MEDIA_1440));
        add_row(OP_READ, 8'h80, 8'd0, 8'd1, 8'd0, 16'd0, 1, bad_drive);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].typed_in, directed_rows[i].want);

        for (int i = 0; i < RANDOM_COUNT; i++)
        begin
            if (i == HOLD_AT)
                hold_request <= 1'b1;
            if (i == QUIET_FROM)
                quiet <= 1'b1;
            else if (i == QUIET_TO)
                quiet <= 1'b0;
            r = random_request();
            send_request(r, 1'b0, none);
        end
        s_axis_tvalid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
